// File: design/tbm_pkg.sv
// Shared types, codes and constants of the tile block-match SSD engine.
package tbm_pkg;

    localparam int MAX_BLOCK_DEF  = 16;
    localparam int PIXEL_BITS_DEF = 16;

    // Search grid: 8 x 8 offsets, -4..3 in each axis
    localparam int SEARCH_N    = 8;
    localparam int SEARCH_BITS = 3;
    localparam int IDX_BITS    = 2 * SEARCH_BITS;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int SIDE_CFG_W  = 5;
    localparam int COARSE_W    = 8;
    localparam int SCALED_W    = 10;
    localparam int OFFSET_W    = 11;
    localparam int SCORE_W     = 40;

    localparam logic [SIDE_CFG_W-1:0]      BLOCK_SIDE_RST = 5'd8;
    localparam logic signed [COARSE_W-1:0] CLAMP_MIN_RST  = -8'sd4;
    localparam logic signed [COARSE_W-1:0] CLAMP_MAX_RST  = 8'sd3;

    localparam logic [IDX_BITS-1:0]    IDX_LAST    = '1;
    localparam logic [SEARCH_BITS-1:0] SEARCH_LAST = '1;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_REF   = 2'd1,
        MODE_WIN   = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIDE = 3'd0,
        CFG_MIN_X      = 3'd1,
        CFG_MIN_Y      = 3'd2,
        CFG_MAX_X      = 3'd3,
        CFG_MAX_Y      = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HOLD
    } state_t;

    // Per-sample control traveling alongside the pixel pipeline
    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last;
        logic [IDX_BITS-1:0] idx;
    } tag_t;

endpackage

// File: design/tbm_ram.sv
// Simple dual-port pixel memory with registered read data.
module tbm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/tbm_seq.sv
// Address sequencer: walks 64 search offsets, each over the B x B block.
module tbm_seq #(
    parameter int MAX_BLOCK = tbm_pkg::MAX_BLOCK_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [$clog2(MAX_BLOCK+1)-1:0]       side,
    output logic [((MAX_BLOCK > 1) ? $clog2(MAX_BLOCK*MAX_BLOCK) : 1)-1:0] ref_addr,
    output logic [$clog2((MAX_BLOCK+tbm_pkg::SEARCH_N-1)**2)-1:0]            win_addr,
    output tbm_pkg::tag_t                        tag
);

    localparam int SIDE_W = $clog2(MAX_BLOCK + 1);
    localparam int RA_W   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK * MAX_BLOCK) : 1;
    localparam int WA_W   = $clog2((MAX_BLOCK + tbm_pkg::SEARCH_N - 1) ** 2);
    localparam int SB     = tbm_pkg::SEARCH_BITS;

    logic              active_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [SIDE_W-1:0] x_reg;
    logic [SIDE_W-1:0] y_reg;
    logic [SB-1:0]     ox_reg;
    logic [SB-1:0]     oy_reg;
    logic [RA_W-1:0]   ref_addr_reg;
    logic [WA_W-1:0]   win_addr_reg;
    logic [WA_W-1:0]   base_reg;

    logic [SIDE_W-1:0] side_m1;
    logic              x_end;
    logic              y_end;
    logic              ox_end;
    logic              oy_end;

    assign side_m1 = side_reg - SIDE_W'(1);
    assign x_end   = (x_reg == side_m1);
    assign y_end   = (y_reg == side_m1);
    assign ox_end  = (ox_reg == tbm_pkg::SEARCH_LAST);
    assign oy_end  = (oy_reg == tbm_pkg::SEARCH_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
        end
        else if (active_reg && x_end && y_end && ox_end && oy_end)
        begin
            active_reg <= 1'b0;
        end
    end

    // Window address: +1 along x, +8 (w - B + 1) at row end; offset base
    // steps +1 in sx and +B (w - 7) when sy advances.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            side_reg     <= side;
            x_reg        <= '0;
            y_reg        <= '0;
            ox_reg       <= '0;
            oy_reg       <= '0;
            ref_addr_reg <= '0;
            win_addr_reg <= '0;
            base_reg     <= '0;
        end
        else if (active_reg)
        begin
            if (!x_end)
            begin
                x_reg        <= x_reg + SIDE_W'(1);
                ref_addr_reg <= ref_addr_reg + RA_W'(1);
                win_addr_reg <= win_addr_reg + WA_W'(1);
            end
            else if (!y_end)
            begin
                x_reg        <= '0;
                y_reg        <= y_reg + SIDE_W'(1);
                ref_addr_reg <= ref_addr_reg + RA_W'(1);
                win_addr_reg <= win_addr_reg + WA_W'(tbm_pkg::SEARCH_N);
            end
            else
            begin
                x_reg        <= '0;
                y_reg        <= '0;
                ref_addr_reg <= '0;
                if (!ox_end)
                begin
                    ox_reg       <= ox_reg + SB'(1);
                    base_reg     <= base_reg + WA_W'(1);
                    win_addr_reg <= base_reg + WA_W'(1);
                end
                else
                begin
                    ox_reg       <= '0;
                    oy_reg       <= oy_reg + SB'(1);
                    base_reg     <= base_reg + WA_W'(side_reg);
                    win_addr_reg <= base_reg + WA_W'(side_reg);
                end
            end
        end
    end

    assign ref_addr  = ref_addr_reg;
    assign win_addr  = win_addr_reg;
    assign tag.valid = active_reg;
    assign tag.first = (x_reg == '0) && (y_reg == '0);
    assign tag.last  = x_end && y_end;
    assign tag.idx   = {oy_reg, ox_reg};

endmodule

// File: design/tbm_ssd.sv
// Squared-difference accumulate unit with running best-score compare.
module tbm_ssd #(
    parameter int MAX_BLOCK  = tbm_pkg::MAX_BLOCK_DEF,
    parameter int PIXEL_BITS = tbm_pkg::PIXEL_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [PIXEL_BITS-1:0]                 ref_pix,
    input  logic [PIXEL_BITS-1:0]                 win_pix,
    input  tbm_pkg::tag_t                         tag_in,
    output logic                                  done,
    output logic [2*PIXEL_BITS+$clog2(MAX_BLOCK*MAX_BLOCK)-1:0] best_score,
    output logic [tbm_pkg::IDX_BITS-1:0]          best_idx
);

    localparam int SQ_W  = 2 * PIXEL_BITS;
    localparam int ACC_W = SQ_W + $clog2(MAX_BLOCK * MAX_BLOCK);

    tbm_pkg::tag_t tag1_reg;
    tbm_pkg::tag_t tag2_reg;
    tbm_pkg::tag_t tag3_reg;

    logic [PIXEL_BITS-1:0]        diff_reg;
    logic [SQ_W-1:0]              sq_reg;
    logic [ACC_W-1:0]             acc_reg;
    logic                         sum_done_reg;
    logic [tbm_pkg::IDX_BITS-1:0] sum_idx_reg;
    logic [ACC_W-1:0]             best_reg;
    logic [tbm_pkg::IDX_BITS-1:0] best_idx_reg;
    logic                         done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg     <= '0;
            tag2_reg     <= '0;
            tag3_reg     <= '0;
            sum_done_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            tag1_reg     <= tag_in;   // lines up with registered RAM data
            tag2_reg     <= tag1_reg;
            tag3_reg     <= tag2_reg;
            sum_done_reg <= tag3_reg.valid && tag3_reg.last;
            done_reg     <= sum_done_reg && (sum_idx_reg == tbm_pkg::IDX_LAST);
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg    <= (ref_pix >= win_pix) ? (ref_pix - win_pix) : (win_pix - ref_pix);
        sq_reg      <= SQ_W'(diff_reg * diff_reg);
        sum_idx_reg <= tag3_reg.idx;
        if (tag3_reg.valid)
        begin
            acc_reg <= tag3_reg.first ? ACC_W'(sq_reg) : (acc_reg + ACC_W'(sq_reg));
        end
        // strict less-than keeps the earliest offset on a tie
        if (sum_done_reg && ((sum_idx_reg == '0) || (acc_reg < best_reg)))
        begin
            best_reg     <= acc_reg;
            best_idx_reg <= sum_idx_reg;
        end
    end

    assign done       = done_reg;
    assign best_score = best_reg;
    assign best_idx   = best_idx_reg;

endmodule

// File: design/tile_block_match_ssd.sv
// Tile block-match engine: one pyramid level of SSD motion search per tile.
// A start transfer (mode 0) clamps the coarse offset to the configured bounds,
// scales it by 4, latches the tile tag and rewinds both load counters. The
// reference block (B*B pixels, mode 1) and the search window ((B+7)^2 pixels,
// mode 2) follow in raster order, one transfer per cycle; extra pixels are
// dropped. The transfer that completes the window launches the search: one
// shared subtract/square/accumulate unit walks all 64 offsets (-4..3 in x and
// y) over the B*B block, one pixel pair per cycle, so the input is stalled
// for the whole search. The lowest sum wins, earliest in scan order on a tie
// (y outer, x inner). The result sits in an output register; loading of the
// next tile proceeds while it waits, and a second search finishing before it
// is taken holds until the register frees.
// Configuration is always ready but should only be written while idle.
module tile_block_match_ssd #(
    parameter int MAX_BLOCK  = tbm_pkg::MAX_BLOCK_DEF,
    parameter int PIXEL_BITS = tbm_pkg::PIXEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          mode,
    input  logic [15:0]                         pixel,
    input  logic signed [7:0]                   coarse_dx,
    input  logic signed [7:0]                   coarse_dy,
    input  logic [9:0]                          tile_col,
    input  logic [9:0]                          tile_row,
    input  logic [3:0]                          frame_index,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [9:0]                          res_tile_col,
    output logic [9:0]                          res_tile_row,
    output logic [3:0]                          res_frame,
    output logic signed [10:0]                  offset_x,
    output logic signed [10:0]                  offset_y,
    output logic [39:0]                         best_score,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tbm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tbm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int WIN_MAX = MAX_BLOCK + tbm_pkg::SEARCH_N - 1;
    localparam int SIDE_W  = $clog2(MAX_BLOCK + 1);
    localparam int WS_W    = $clog2(WIN_MAX + 1);
    localparam int RA_W    = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK * MAX_BLOCK) : 1;
    localparam int WA_W    = $clog2(WIN_MAX * WIN_MAX);
    localparam int RC_W    = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
    localparam int WC_W    = $clog2(WIN_MAX * WIN_MAX + 1);
    localparam int ACC_W   = 2 * PIXEL_BITS + $clog2(MAX_BLOCK * MAX_BLOCK);
    localparam int SB      = tbm_pkg::SEARCH_BITS;
    localparam int SW      = tbm_pkg::SCORE_W;

    // ---------------- configuration registers ----------------
    logic [tbm_pkg::SIDE_CFG_W-1:0]      block_side_reg;
    logic signed [tbm_pkg::COARSE_W-1:0] clamp_min_x_reg;
    logic signed [tbm_pkg::COARSE_W-1:0] clamp_min_y_reg;
    logic signed [tbm_pkg::COARSE_W-1:0] clamp_max_x_reg;
    logic signed [tbm_pkg::COARSE_W-1:0] clamp_max_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_side_reg  <= tbm_pkg::BLOCK_SIDE_RST;
            clamp_min_x_reg <= tbm_pkg::CLAMP_MIN_RST;
            clamp_min_y_reg <= tbm_pkg::CLAMP_MIN_RST;
            clamp_max_x_reg <= tbm_pkg::CLAMP_MAX_RST;
            clamp_max_y_reg <= tbm_pkg::CLAMP_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tbm_pkg::cfg_idx_t'(cfg_index))
                tbm_pkg::CFG_BLOCK_SIDE: block_side_reg  <= cfg_data[tbm_pkg::SIDE_CFG_W-1:0];
                tbm_pkg::CFG_MIN_X:      clamp_min_x_reg <= cfg_data;
                tbm_pkg::CFG_MIN_Y:      clamp_min_y_reg <= cfg_data;
                tbm_pkg::CFG_MAX_X:      clamp_max_x_reg <= cfg_data;
                tbm_pkg::CFG_MAX_Y:      clamp_max_y_reg <= cfg_data;
                default: ;  // unmapped index: dropped
            endcase
        end
    end

    // Effective side: 0 acts as 1, anything above MAX_BLOCK as MAX_BLOCK
    logic [SIDE_W-1:0] side_now;
    logic [WS_W-1:0]   wside_now;
    logic [RC_W-1:0]   ref_total;
    logic [WC_W-1:0]   win_total;

    always_comb
    begin
        if (block_side_reg == '0)
        begin
            side_now = SIDE_W'(1);
        end
        else if (int'(block_side_reg) > MAX_BLOCK)
        begin
            side_now = SIDE_W'(MAX_BLOCK);
        end
        else
        begin
            side_now = SIDE_W'(block_side_reg);
        end
    end

    assign wside_now = WS_W'(side_now) + WS_W'(tbm_pkg::SEARCH_N - 1);
    assign ref_total = RC_W'(side_now * side_now);
    assign win_total = WC_W'(wside_now * wside_now);

    // ---------------- control FSM ----------------
    tbm_pkg::state_t state_reg;
    tbm_pkg::state_t state_next;

    logic in_xfer;
    logic out_free;
    logic res_load;
    logic unit_done;
    logic win_last;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tbm_pkg::ST_IDLE:
            begin
                if (win_last)
                begin
                    state_next = tbm_pkg::ST_SEARCH;
                end
            end
            tbm_pkg::ST_SEARCH:
            begin
                if (unit_done)
                begin
                    state_next = out_free ? tbm_pkg::ST_IDLE : tbm_pkg::ST_HOLD;
                end
            end
            tbm_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = tbm_pkg::ST_IDLE;
                end
            end
            default: state_next = tbm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        res_load = 1'b0;
        unique case (state_reg)
            tbm_pkg::ST_IDLE:   in_stall = 1'b0;
            tbm_pkg::ST_SEARCH: res_load = unit_done && out_free;
            tbm_pkg::ST_HOLD:   res_load = out_free;
            default: ;
        endcase
    end

    // ---------------- load path ----------------
    logic [RC_W-1:0]                     ref_count_reg;
    logic [WC_W-1:0]                     win_count_reg;
    logic signed [tbm_pkg::SCALED_W-1:0] scaled_dx_reg;
    logic signed [tbm_pkg::SCALED_W-1:0] scaled_dy_reg;
    logic [9:0]                          tag_col_reg;
    logic [9:0]                          tag_row_reg;
    logic [3:0]                          tag_frame_reg;

    logic is_start;
    logic ref_we;
    logic win_we;
    logic signed [tbm_pkg::COARSE_W-1:0] cx_lo;
    logic signed [tbm_pkg::COARSE_W-1:0] cy_lo;
    logic signed [tbm_pkg::COARSE_W-1:0] cx;
    logic signed [tbm_pkg::COARSE_W-1:0] cy;

    assign is_start = in_xfer && (mode == tbm_pkg::MODE_START);
    assign ref_we   = in_xfer && (mode == tbm_pkg::MODE_REF) && (ref_count_reg < ref_total);
    assign win_we   = in_xfer && (mode == tbm_pkg::MODE_WIN) && (win_count_reg < win_total);
    assign win_last = win_we && (WC_W'(win_count_reg + WC_W'(1)) == win_total);

    // max with the low bound first, then min with the high bound
    assign cx_lo = (coarse_dx < clamp_min_x_reg) ? clamp_min_x_reg : coarse_dx;
    assign cy_lo = (coarse_dy < clamp_min_y_reg) ? clamp_min_y_reg : coarse_dy;
    assign cx    = (cx_lo > clamp_max_x_reg) ? clamp_max_x_reg : cx_lo;
    assign cy    = (cy_lo > clamp_max_y_reg) ? clamp_max_y_reg : cy_lo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg <= '0;
            win_count_reg <= '0;
            scaled_dx_reg <= '0;
            scaled_dy_reg <= '0;
            tag_col_reg   <= '0;
            tag_row_reg   <= '0;
            tag_frame_reg <= '0;
        end
        else
        begin
            if (is_start)
            begin
                ref_count_reg <= '0;
                win_count_reg <= '0;
                scaled_dx_reg <= {cx, 2'b00};   // times 4
                scaled_dy_reg <= {cy, 2'b00};
                tag_col_reg   <= tile_col;
                tag_row_reg   <= tile_row;
                tag_frame_reg <= frame_index;
            end
            if (ref_we)
            begin
                ref_count_reg <= ref_count_reg + RC_W'(1);
            end
            if (win_we)
            begin
                win_count_reg <= win_count_reg + WC_W'(1);
            end
        end
    end

    // ---------------- storage, sequencer, accumulate unit ----------------
    logic [RA_W-1:0]       ref_raddr;
    logic [WA_W-1:0]       win_raddr;
    logic [PIXEL_BITS-1:0] ref_pix;
    logic [PIXEL_BITS-1:0] win_pix;
    tbm_pkg::tag_t         seq_tag;
    logic [ACC_W-1:0]      unit_score;
    logic [tbm_pkg::IDX_BITS-1:0] unit_idx;

    tbm_ram #(
        .DEPTH (MAX_BLOCK * MAX_BLOCK),
        .WIDTH (PIXEL_BITS),
        .AW    (RA_W)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_count_reg[RA_W-1:0]),
        .wdata (pixel[PIXEL_BITS-1:0]),
        .raddr (ref_raddr),
        .rdata (ref_pix)
    );

    tbm_ram #(
        .DEPTH (WIN_MAX * WIN_MAX),
        .WIDTH (PIXEL_BITS),
        .AW    (WA_W)
    ) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_count_reg[WA_W-1:0]),
        .wdata (pixel[PIXEL_BITS-1:0]),
        .raddr (win_raddr),
        .rdata (win_pix)
    );

    tbm_seq #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (win_last),
        .side     (side_now),
        .ref_addr (ref_raddr),
        .win_addr (win_raddr),
        .tag      (seq_tag)
    );

    tbm_ssd #(
        .MAX_BLOCK  (MAX_BLOCK),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ssd (
        .clk        (clk),
        .rst_n      (rst_n),
        .ref_pix    (ref_pix),
        .win_pix    (win_pix),
        .tag_in     (seq_tag),
        .done       (unit_done),
        .best_score (unit_score),
        .best_idx   (unit_idx)
    );

    // ---------------- result register ----------------
    logic                               out_valid_reg;
    logic [9:0]                         res_col_reg;
    logic [9:0]                         res_row_reg;
    logic [3:0]                         res_frame_reg;
    logic signed [tbm_pkg::OFFSET_W-1:0] offset_x_reg;
    logic signed [tbm_pkg::OFFSET_W-1:0] offset_y_reg;
    logic [SW-1:0]                      score_reg;

    logic [SB-1:0]                      best_ox;
    logic [SB-1:0]                      best_oy;
    logic signed [tbm_pkg::OFFSET_W-1:0] search_x;
    logic signed [tbm_pkg::OFFSET_W-1:0] search_y;
    logic [ACC_W+SW-1:0]                score_wide;

    assign best_ox = unit_idx[SB-1:0];
    assign best_oy = unit_idx[2*SB-1:SB];
    // index 0..7 minus 4 is the index with its top bit flipped, as signed
    assign search_x = {{(tbm_pkg::OFFSET_W-SB+1){~best_ox[SB-1]}}, best_ox[SB-2:0]};
    assign search_y = {{(tbm_pkg::OFFSET_W-SB+1){~best_oy[SB-1]}}, best_oy[SB-2:0]};
    assign score_wide = (ACC_W+SW)'(unit_score);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_col_reg   <= tag_col_reg;
            res_row_reg   <= tag_row_reg;
            res_frame_reg <= tag_frame_reg;
            offset_x_reg  <= tbm_pkg::OFFSET_W'(scaled_dx_reg) + search_x;
            offset_y_reg  <= tbm_pkg::OFFSET_W'(scaled_dy_reg) + search_y;
            score_reg     <= score_wide[SW-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign res_tile_col = res_col_reg;
    assign res_tile_row = res_row_reg;
    assign res_frame    = res_frame_reg;
    assign offset_x     = offset_x_reg;
    assign offset_y     = offset_y_reg;
    assign best_score   = score_reg;

endmodule

// File: design/tbm_checker.sv
// Port-level assertions for the tile block-match engine, bound to the top.
module tbm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [1:0]                     mode,
    input logic [15:0]                    pixel,
    input logic signed [7:0]              coarse_dx,
    input logic signed [7:0]              coarse_dy,
    input logic [9:0]                     tile_col,
    input logic [9:0]                     tile_row,
    input logic [3:0]                     frame_index,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [9:0]                     res_tile_col,
    input logic [9:0]                     res_tile_row,
    input logic [3:0]                     res_frame,
    input logic signed [10:0]             offset_x,
    input logic signed [10:0]             offset_y,
    input logic [39:0]                    best_score,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [tbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [tbm_pkg::CFG_DATA_W-1:0] cfg_data
);

    // held result stays put while the sink stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(best_score)
            && $stable(offset_x) && $stable(offset_y))
        else $error("result changed while stalled");

    // a fresh result only follows a search phase, which stalls the input
    a_res_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a preceding search");

    // a search walks all 64 offsets, so the input stall it raises must not end early
    a_search_len: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> ##63 in_stall)
        else $error("search ended too early");

    // scaled coarse offset plus search offset stays within -516..511
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (offset_x >= -11'sd516) && (offset_x <= 11'sd511)
            && (offset_y >= -11'sd516) && (offset_y <= 11'sd511))
        else $error("offset out of range");

endmodule

bind tile_block_match_ssd tbm_checker u_tbm_checker (.*);
